[hw/rtl/uet_pkg.sv]
// ----------------------------------------------------------------------------
// uet_pkg
// Shared sizes, codes and controller/datapath command types for the
// undirected edge table.
// ----------------------------------------------------------------------------
package uet_pkg;

  localparam int unsigned MaxNodes  = 256;
  localparam int unsigned MaxDegree = 16;
  localparam int unsigned IdW       = 20;
  localparam int unsigned SlotW     = $clog2(MaxNodes);
  localparam int unsigned CntW      = $clog2(MaxNodes + 1);
  localparam int unsigned DegW      = $clog2(MaxDegree + 1);
  localparam int unsigned DIdxW     = $clog2(MaxDegree);
  localparam int unsigned NbAddrW   = SlotW + DIdxW;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SELF       = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_LIST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OK_ADD  = 2'd0,
    Q_MISS  = 2'd1,
    Q_EMPTY = 2'd2,
    Q_NB    = 2'd3
  } out_kind_e;

  typedef struct packed {
    logic      load_in;
    logic      scan_rd;
    logic      scan_cmp;
    logic      deg_rd_a;
    logic      deg_rd_b;
    logic      deg_cap_a;
    logic      deg_cap_b;
    logic      k_clr;
    logic      k_inc;
    logic      nb_rd;
    logic      id_rd;
    logic      wr_a;
    logic      wr_b;
    logic      app_a;
    logic      app_b;
    logic      out_load;
    out_kind_e out_kind;
    status_e   out_status;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic self_pair;
    logic scan_end;
    logic scan_hit;
    logic found_a;
    logic found_b;
    logic no_room;
    logic deg_full;
    logic deg_rd_zero;
    logic k_end;
    logic k_last;
    logic nb_match;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/uet_if.sv]
// ----------------------------------------------------------------------------
// uet_in_if / uet_out_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface uet_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [uet_pkg::IdW-1:0]    first_id;
  logic [uet_pkg::IdW-1:0]    second_id;
  modport source (output valid, mode, first_id, second_id, input ready);
  modport sink   (input valid, mode, first_id, second_id, output ready);
endinterface

interface uet_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic                       found;
  logic                       has_neighbor;
  logic [uet_pkg::IdW-1:0]    neighbor_id;
  logic                       last;
  modport source (output valid, status, found, has_neighbor, neighbor_id, last,
                  input ready);
  modport sink   (input valid, status, found, has_neighbor, neighbor_id, last,
                  output ready);
endinterface

[hw/rtl/uet_ctrl.sv]
// ----------------------------------------------------------------------------
// uet_ctrl
// Sequencer: node scan, degree reads, duplicate scan, table update and
// result emission, issued as commands to the datapath.
// ----------------------------------------------------------------------------
module uet_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  uet_pkg::sts_t sts_i,
  output uet_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_SCAN_RD, S_SCAN_CMP, S_DEG_A, S_DEG_B, S_DEG_CAP,
    S_DUP_RD, S_DUP_CMP, S_CHK, S_WR_A, S_WR_B, S_APP_A, S_APP_B,
    S_Q_DEG, S_Q_CAP, S_NB_RD, S_ID_RD, S_EMIT, S_RESULT
  } state_e;

  state_e              state_q, state_d;
  uet_pkg::out_kind_e  kind_q, kind_d;
  uet_pkg::status_e    res_q, res_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.out_kind   = kind_q;
    cmd_o.out_status = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_START;
        end
      end
      S_START: begin
        if (!sts_i.mode && sts_i.self_pair) begin
          kind_d  = uet_pkg::OK_ADD;
          res_d   = uet_pkg::ST_SELF;
          state_d = S_RESULT;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts_i.scan_end || sts_i.scan_hit) begin
          if (sts_i.mode) begin
            if (sts_i.found_a) begin
              state_d = S_Q_DEG;
            end else begin
              kind_d  = uet_pkg::Q_MISS;
              res_d   = uet_pkg::ST_OK;
              state_d = S_RESULT;
            end
          end else if (sts_i.no_room) begin
            kind_d  = uet_pkg::OK_ADD;
            res_d   = uet_pkg::ST_TABLE_FULL;
            state_d = S_RESULT;
          end else begin
            state_d = S_DEG_A;
          end
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        state_d = S_SCAN_RD;
      end
      S_DEG_A: begin
        cmd_o.deg_rd_a = 1'b1;
        state_d = S_DEG_B;
      end
      S_DEG_B: begin
        cmd_o.deg_cap_a = 1'b1;
        cmd_o.deg_rd_b  = 1'b1;
        state_d = S_DEG_CAP;
      end
      S_DEG_CAP: begin
        cmd_o.deg_cap_b = 1'b1;
        cmd_o.k_clr     = 1'b1;
        state_d = (sts_i.found_a && sts_i.found_b) ? S_DUP_RD : S_CHK;
      end
      // Walk the first node's list looking for the second slot
      S_DUP_RD: begin
        if (sts_i.k_end) begin
          state_d = S_CHK;
        end else begin
          cmd_o.nb_rd = 1'b1;
          state_d = S_DUP_CMP;
        end
      end
      S_DUP_CMP: begin
        cmd_o.k_inc = 1'b1;
        if (sts_i.nb_match) begin
          kind_d  = uet_pkg::OK_ADD;
          res_d   = uet_pkg::ST_OK;
          state_d = S_RESULT;
        end else begin
          state_d = S_DUP_RD;
        end
      end
      S_CHK: begin
        if (sts_i.deg_full) begin
          kind_d  = uet_pkg::OK_ADD;
          res_d   = uet_pkg::ST_LIST_FULL;
          state_d = S_RESULT;
        end else begin
          state_d = S_WR_A;
        end
      end
      S_WR_A: begin
        cmd_o.wr_a = !sts_i.found_a;
        state_d = S_WR_B;
      end
      S_WR_B: begin
        cmd_o.wr_b = !sts_i.found_b;
        state_d = S_APP_A;
      end
      S_APP_A: begin
        cmd_o.app_a = 1'b1;
        state_d = S_APP_B;
      end
      S_APP_B: begin
        cmd_o.app_b = 1'b1;
        kind_d  = uet_pkg::OK_ADD;
        res_d   = uet_pkg::ST_OK;
        state_d = S_RESULT;
      end
      S_Q_DEG: begin
        cmd_o.deg_rd_a = 1'b1;
        state_d = S_Q_CAP;
      end
      S_Q_CAP: begin
        cmd_o.deg_cap_a = 1'b1;
        cmd_o.k_clr     = 1'b1;
        res_d = uet_pkg::ST_OK;
        if (sts_i.deg_rd_zero) begin
          kind_d  = uet_pkg::Q_EMPTY;
          state_d = S_RESULT;
        end else begin
          kind_d  = uet_pkg::Q_NB;
          state_d = S_NB_RD;
        end
      end
      // Fetch neighbor slot, then its id, then hand out one beat
      S_NB_RD: begin
        cmd_o.nb_rd = 1'b1;
        state_d = S_ID_RD;
      end
      S_ID_RD: begin
        cmd_o.id_rd = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.k_inc    = 1'b1;
          state_d = sts_i.k_last ? S_IDLE : S_NB_RD;
        end
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and pending result code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= uet_pkg::OK_ADD;
      res_q   <= uet_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      res_q   <= res_d;
    end
  end

`ifndef SYNTH
  a_emit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> sts_i.found_a)
    else $error("neighbor beat without a found node");
  a_update_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APP_A) |-> !sts_i.deg_full)
    else $error("append on a full neighbor list");
  a_result_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && state_q == S_RESULT) |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle after a single result");
`endif

endmodule

[hw/rtl/uet_dp.sv]
// ----------------------------------------------------------------------------
// uet_dp
// Datapath: node id, degree and neighbor slot memories, scan registers and
// the result output register.
// ----------------------------------------------------------------------------
module uet_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  uet_in_if.sink          in_i,
  uet_out_if.source       out_o,
  input  logic            in_ready_i,
  input  uet_pkg::cmd_t   cmd_i,
  output uet_pkg::sts_t   sts_o
);

  localparam int unsigned IdW   = uet_pkg::IdW;
  localparam int unsigned SlotW = uet_pkg::SlotW;
  localparam int unsigned CntW  = uet_pkg::CntW;
  localparam int unsigned DegW  = uet_pkg::DegW;
  localparam int unsigned DIdxW = uet_pkg::DIdxW;

  // Memories
  logic [IdW-1:0]   node_mem [uet_pkg::MaxNodes];
  logic [DegW-1:0]  deg_mem  [uet_pkg::MaxNodes];
  logic [SlotW-1:0] nb_mem   [uet_pkg::MaxNodes * uet_pkg::MaxDegree];

  logic             mode_q;
  logic [IdW-1:0]   a_q, b_q;
  logic [CntW-1:0]  s_q, cnt_q;
  logic             fa_q, fb_q;
  logic [SlotW-1:0] sa_q, sb_q;
  logic [DegW-1:0]  deg_a_q, deg_b_q, deg_rd_q;
  logic [DegW-1:0]  k_q;
  logic [IdW-1:0]   node_rd_q;
  logic [SlotW-1:0] nb_rd_q;
  logic             out_valid_q;

  logic [SlotW-1:0]           node_raddr, deg_raddr;
  logic [uet_pkg::NbAddrW-1:0] nb_raddr;
  logic [CntW:0]              need_cnt;
  logic [DegW-1:0]            k_next;

  assign node_raddr = cmd_i.id_rd ? nb_rd_q : s_q[SlotW-1:0];
  assign deg_raddr  = cmd_i.deg_rd_b ? sb_q : sa_q;
  assign nb_raddr   = {sa_q, k_q[DIdxW-1:0]};
  assign need_cnt   = {1'b0, cnt_q} + (CntW+1)'(!fa_q) + (CntW+1)'(!fb_q);
  assign k_next     = k_q + DegW'(1);

  // Node id memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      node_mem[cnt_q[SlotW-1:0]] <= a_q;
    end else if (cmd_i.wr_b) begin
      node_mem[cnt_q[SlotW-1:0]] <= b_q;
    end
    if (cmd_i.scan_rd || cmd_i.id_rd) begin
      node_rd_q <= node_mem[node_raddr];
    end
  end

  // Degree memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.app_a) begin
      deg_mem[sa_q] <= deg_a_q + DegW'(1);
    end else if (cmd_i.app_b) begin
      deg_mem[sb_q] <= deg_b_q + DegW'(1);
    end
    if (cmd_i.deg_rd_a || cmd_i.deg_rd_b) begin
      deg_rd_q <= deg_mem[deg_raddr];
    end
  end

  // Neighbor slot memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.app_a) begin
      nb_mem[{sa_q, deg_a_q[DIdxW-1:0]}] <= sb_q;
    end else if (cmd_i.app_b) begin
      nb_mem[{sb_q, deg_b_q[DIdxW-1:0]}] <= sa_q;
    end
    if (cmd_i.nb_rd) begin
      nb_rd_q <= nb_mem[nb_raddr];
    end
  end

  // Request, scan and degree registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= in_i.mode;
      a_q    <= in_i.first_id;
      b_q    <= in_i.second_id;
      fa_q   <= 1'b0;
      fb_q   <= 1'b0;
      s_q    <= '0;
    end else if (cmd_i.scan_cmp) begin
      if (!fa_q && node_rd_q == a_q) begin
        fa_q <= 1'b1;
        sa_q <= s_q[SlotW-1:0];
      end
      if (!fb_q && node_rd_q == b_q) begin
        fb_q <= 1'b1;
        sb_q <= s_q[SlotW-1:0];
      end
      s_q <= s_q + CntW'(1);
    end else if (cmd_i.wr_a) begin
      sa_q <= cnt_q[SlotW-1:0];
    end else if (cmd_i.wr_b) begin
      sb_q <= cnt_q[SlotW-1:0];
    end
    if (cmd_i.deg_cap_a) begin
      deg_a_q <= fa_q ? deg_rd_q : '0;
    end
    if (cmd_i.deg_cap_b) begin
      deg_b_q <= fb_q ? deg_rd_q : '0;
    end
    if (cmd_i.k_clr) begin
      k_q <= '0;
    end else if (cmd_i.k_inc) begin
      k_q <= k_next;
    end
  end

  // Node count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.wr_a || cmd_i.wr_b) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_o.status       <= cmd_i.out_status;
      out_o.found        <= (cmd_i.out_kind == uet_pkg::Q_EMPTY) ||
                            (cmd_i.out_kind == uet_pkg::Q_NB);
      out_o.has_neighbor <= (cmd_i.out_kind == uet_pkg::Q_NB);
      out_o.neighbor_id  <= (cmd_i.out_kind == uet_pkg::Q_NB) ? node_rd_q : '0;
      out_o.last         <= (cmd_i.out_kind == uet_pkg::Q_NB) ? (k_next == deg_a_q)
                                                              : 1'b1;
    end
  end

  assign out_o.valid = out_valid_q;
  assign in_i.ready  = in_ready_i;

  // Status back to the sequencer
  always_comb begin
    sts_o.mode        = mode_q;
    sts_o.self_pair   = (a_q == b_q);
    sts_o.scan_end    = (s_q == cnt_q);
    sts_o.scan_hit    = mode_q ? fa_q : (fa_q && fb_q);
    sts_o.found_a     = fa_q;
    sts_o.found_b     = fb_q;
    sts_o.no_room     = (need_cnt > (CntW+1)'(uet_pkg::MaxNodes));
    sts_o.deg_full    = (deg_a_q == DegW'(uet_pkg::MaxDegree)) ||
                        (deg_b_q == DegW'(uet_pkg::MaxDegree));
    sts_o.deg_rd_zero = (deg_rd_q == '0);
    sts_o.k_end       = (k_q == deg_a_q);
    sts_o.k_last      = (k_next == deg_a_q);
    sts_o.nb_match    = (nb_rd_q == sb_q);
    sts_o.out_free    = !out_valid_q || out_o.ready;
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(uet_pkg::MaxNodes))
    else $error("node count beyond table size");
  a_wr_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_a || cmd_i.wr_b) |-> (cnt_q < CntW'(uet_pkg::MaxNodes)))
    else $error("node write into a full table");
  a_wr_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.app_a && cmd_i.app_b) && !(cmd_i.wr_a && cmd_i.wr_b))
    else $error("two writes to one memory port");
`endif

endmodule

[hw/rtl/undirected_edge_table.sv]
// An add or a query is dominated by the node id scan, which reads one slot
// at a time through the single node memory read port.
// One request is worked at a time; a new beat is taken once the last result
// is loaded into the output register, even while that result still waits.
// Reset empties the table at once (node count to zero); no clearing pass.
// ----------------------------------------------------------------------------
// undirected_edge_table
// Bounded adjacency-list graph: adds undirected pairs of node ids and
// returns the neighbor ids of a queried node, one result beat each.
// ----------------------------------------------------------------------------
module undirected_edge_table (
  input  logic      clk_i,
  input  logic      rst_ni,
  uet_in_if.sink    in_i,
  uet_out_if.source out_o
);

  uet_pkg::cmd_t cmd;
  uet_pkg::sts_t sts;
  logic          in_ready;

  uet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  uet_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .in_ready_i (in_ready),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule
